[rtl/lpfp_pkg.sv]
// lpfp_pkg: shared types and constants of the length-prefixed frame parser.
// No dependencies; imported by all lpfp modules.
`default_nettype none

package lpfp_pkg;

    // Header layout: 4 length bytes, 1 type byte, 4 id bytes
    localparam logic [31:0] FIELD_BYTES  = 32'd4;
    localparam logic [31:0] HDR_BYTES    = 32'd9;
    localparam logic [31:0] POS_TYPE     = 32'd4;
    localparam logic [31:0] POS_HDR_LAST = 32'd8;

    // Types below this limit have their payload delivered
    localparam logic [7:0] DELIVER_TYPE_LIMIT = 8'd2;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  frame_type;
        logic [31:0] frame_id;
        logic [31:0] frame_length;
        logic [7:0]  data_byte;
        logic        last;
        logic        short_length_error;
    } lpfp_result_t;

    // Handshake control between the top level and the output register
    typedef struct packed {
        logic load;
        logic stall;
    } lpfp_ctl_t;

endpackage

`default_nettype wire

[rtl/lpfp_if.sv]
// lpfp_rx_if / lpfp_res_if: valid/ready channels of the frame parser.
// No dependencies.
`default_nettype none

interface lpfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_res_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  frame_type;
    logic [31:0] frame_id;
    logic [31:0] frame_length;
    logic [7:0]  data_byte;
    logic        last;
    logic        short_length_error;

    modport source (output valid, output item_kind, output frame_type, output frame_id,
                    output frame_length, output data_byte, output last,
                    output short_length_error, input ready);
    modport sink   (input valid, input item_kind, input frame_type, input frame_id,
                    input frame_length, input data_byte, input last,
                    input short_length_error, output ready);
endinterface

`default_nettype wire

[rtl/length_prefixed_frame_parser_top.sv]
// length_prefixed_frame_parser_top: byte stream in, header/payload results out.
// Depends on lpfp_pkg, lpfp_if, lpfp_parse, lpfp_outreg.
//
//   channel | dir | payload                                       | handshake
//   rx      | in  | rx_byte                                       | valid/ready
//   res     | out | item_kind, frame_type, frame_id, frame_length,| valid/ready
//           |     | data_byte, last, short_length_error           |
//
// One byte per clock cycle sustained while res does not stall; a result passes through the
// input register and then the result register before it is valid on res.
// The parse step between the two registers is a few 32-bit compares and one increment.
// rst_n clears the input and result valid flags and the frame position.
// A stall on res holds the result register; rx keeps accepting while the
// input byte makes no result or the result register is free.
`default_nettype none

module length_prefixed_frame_parser_top
    import lpfp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpfp_rx_if.sink    rx,
    lpfp_res_if.source res
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         produce;
    logic         step;
    lpfp_result_t result;
    lpfp_result_t out_result;
    lpfp_ctl_t    ctl;

    // Advance the held byte unless its result would hit a stalled register
    assign step     = in_valid_reg && !(produce && ctl.stall);
    assign rx.ready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    lpfp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .produce (produce),
        .result  (result)
    );

    lpfp_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && produce),
        .result     (result),
        .out_ready  (res.ready),
        .out_valid  (res.valid),
        .out_result (out_result),
        .ctl        (ctl)
    );

    assign res.item_kind          = out_result.item_kind;
    assign res.frame_type         = out_result.frame_type;
    assign res.frame_id           = out_result.frame_id;
    assign res.frame_length       = out_result.frame_length;
    assign res.data_byte          = out_result.data_byte;
    assign res.last               = out_result.last;
    assign res.short_length_error = out_result.short_length_error;

    // Input side only backs up when a result is blocked
    a_ready_low_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> (in_valid_reg && produce && ctl.stall))
        else $error("input stalled without a blocked result");

    // A held byte that makes a result and meets a stall stays put
    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte lost during stall");

    // The result register loads exactly when a producing byte advances
    a_load_matches: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load == (step && produce))
        else $error("result load out of step with the parser");

endmodule

`default_nettype wire

[rtl/lpfp_parse.sv]
// lpfp_parse: frame position counter, header field capture and result build.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_parse
    import lpfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   rx_byte,
    output logic              produce,
    output lpfp_result_t      result
);

    logic [31:0] pos_reg,  pos_next;
    logic [31:0] len_reg,  len_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] id_reg,   id_next;

    logic        short_len;
    logic        frame_end;
    logic        deliver;

    assign deliver = (type_reg < DELIVER_TYPE_LIMIT);

    // Next state and result for the byte at the current position
    always_comb
    begin
        pos_next   = pos_reg + 32'd1;
        len_next   = len_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        produce    = 1'b0;
        short_len  = 1'b0;
        frame_end  = 1'b0;
        result     = '0;

        if (pos_reg < FIELD_BYTES)
        begin
            // little-endian length, first byte clears the rest
            case (pos_reg[1:0])
                2'd0:    len_next = {24'd0, rx_byte};
                2'd1:    len_next[15:8]  = rx_byte;
                2'd2:    len_next[23:16] = rx_byte;
                default: len_next[31:24] = rx_byte;
            endcase
        end
        else if (pos_reg == POS_TYPE)
        begin
            type_next = rx_byte;
        end
        else if (pos_reg <= POS_HDR_LAST)
        begin
            // id bytes sit at positions 5..8; low two bits give 1,2,3,0
            case (pos_reg[1:0])
                2'd1:    id_next = {24'd0, rx_byte};
                2'd2:    id_next[15:8]  = rx_byte;
                2'd3:    id_next[23:16] = rx_byte;
                default: id_next[31:24] = rx_byte;
            endcase

            if (pos_reg == POS_HDR_LAST)
            begin
                short_len = (len_reg < HDR_BYTES);
                if (short_len)
                begin
                    len_next = HDR_BYTES;
                end
                pos_next  = (len_next == HDR_BYTES) ? 32'd0 : HDR_BYTES;
                produce   = 1'b1;
                result.item_kind          = KIND_HEADER;
                result.frame_type         = type_reg;
                result.frame_id           = id_next;
                result.frame_length       = len_next;
                result.data_byte          = 8'd0;
                result.last               = (len_next == HDR_BYTES) || !deliver;
                result.short_length_error = short_len;
            end
        end
        else
        begin
            // payload byte
            frame_end = (pos_reg == (len_reg - 32'd1));
            pos_next  = frame_end ? 32'd0 : pos_reg + 32'd1;
            produce   = deliver;
            result.item_kind          = KIND_PAYLOAD;
            result.frame_type         = type_reg;
            result.frame_id           = id_reg;
            result.frame_length       = len_reg;
            result.data_byte          = rx_byte;
            result.last               = frame_end;
            result.short_length_error = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            type_reg <= '0;
            id_reg   <= '0;
        end
        else if (step)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            type_reg <= type_next;
            id_reg   <= id_next;
        end
    end

    // Inside a payload the position always stays below the frame length
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg >= HDR_BYTES) |-> (pos_reg < len_reg))
        else $error("payload position beyond frame length");

    // A last payload result returns the parser to the start of a frame
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (step && produce && result.item_kind == KIND_PAYLOAD && result.last)
        |=> (pos_reg == 32'd0))
        else $error("position not cleared after last payload byte");

    // A short length is reported as a minimal, final header
    a_short_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && result.short_length_error)
        |-> (result.last && result.frame_length == HDR_BYTES
             && result.item_kind == KIND_HEADER))
        else $error("short length header malformed");

endmodule

`default_nettype wire

[rtl/lpfp_outreg.sv]
// lpfp_outreg: result register that holds a request until the sink takes it.
// Depends on lpfp_pkg.
`default_nettype none

module lpfp_outreg
    import lpfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire lpfp_result_t result,
    input  wire logic         out_ready,
    output logic              out_valid,
    output lpfp_result_t      out_result,
    output lpfp_ctl_t         ctl
);

    logic         valid_reg;
    lpfp_result_t data_reg;

    assign ctl.load   = load;
    assign ctl.stall  = valid_reg && !out_ready;
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    // Valid flag: set on load, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    // Never overwrite a request the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> !ctl.stall)
        else $error("result register overwritten while stalled");

    // A stalled request stays valid and unchanged
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled request changed");

    // A load always presents a request on the next cycle
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded request not valid");

endmodule

`default_nettype wire
